@@ rtl/rvp_pkg.sv @@
`default_nettype none
package rvp_pkg;
	localparam int unsigned MaxPayloadReset = 8900;
	localparam logic [6:0] PayloadKindReset = 7'd96;
	localparam int unsigned QueueDepth = 4;

	// configuration register indexes
	localparam logic [2:0] RegMaxPayload  = 3'd0;
	localparam logic [2:0] RegPayloadKind = 3'd1;
	localparam logic [2:0] RegSyncSource  = 3'd2;
	localparam logic [2:0] RegSeqStart    = 3'd3;
	localparam logic [2:0] RegCodec       = 3'd4;
	localparam logic [2:0] RegInterleave  = 3'd5;
	localparam logic [2:0] RegJpegTq      = 3'd6;
	localparam logic [2:0] RegJpegDims    = 3'd7;

	localparam logic [1:0] CodecH264  = 2'd0;
	localparam logic [1:0] CodecMjpeg = 2'd1;

	localparam logic [7:0] FuTypeA  = 8'd28;
	localparam logic [7:0] FuStart  = 8'h80;
	localparam logic [7:0] FuEnd    = 8'h40;
	localparam logic [7:0] RtpVer   = 8'h80;
	localparam logic [7:0] IlvMagic = 8'h24;

	// one classified frame byte handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        start;     // open a new packet before this byte
		logic        hdr_only;  // packet header only, no payload byte
		logic        last;      // last payload byte of its packet
		logic        marker;
		logic        fu;        // fu-a payload header present
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
		logic [15:0] pay;       // payload bytes in this packet
		logic [23:0] offset;
		logic [31:0] stamp;
	} job_t;
endpackage
`default_nettype wire

@@ rtl/rtp_video_packetizer.sv @@
`default_nettype none
// rtp video packetizer
// input channel: one frame byte per word (data_byte) with valid/stall; the
// first byte of a frame carries frame_first, frame_length, frame_time and
// param_frame. output channel: one packet-stream word per cycle (out_byte,
// packet_first, packet_last) with valid/stall.
// a front stage classifies each byte (packet start, fragment, marker, fu-a
// bytes) and pushes it into a four-entry queue; a back stage expands each
// packet start into its prefix/rtp/payload header bytes, then the payload byte.
// throughput: payload bytes flow at one per cycle while the output is not
// stalled; a packet start adds 12 to 24 header bytes, during which the queue
// can fill and stall the input. an accepted byte is written into the queue,
// then registered by the back stage as its first output word. reset clears
// all frame state and the sequence counter; config writes go straight to
// registers (writing seq_start reloads the counter). a receiver stall holds
// the output word and backs up through the queue to the input once it fills.
module rtp_video_packetizer #(
	parameter int unsigned QueueDepth = rvp_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_first,
	input  wire logic [23:0] frame_length,
	input  wire logic [31:0] frame_time,
	input  wire logic        param_frame,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             packet_first,
	output logic             packet_last
);
	logic [15:0] max_payload_q, jtq_q, jdims_q;
	logic [6:0]  kind_q;
	logic [31:0] ssrc_q;
	logic [1:0]  codec_q;
	logic        ilv_q, seq_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= 16'(rvp_pkg::MaxPayloadReset);
			kind_q <= rvp_pkg::PayloadKindReset;
			ssrc_q <= '0; codec_q <= '0;
			ilv_q <= 1'b0; jtq_q <= '0; jdims_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rvp_pkg::RegMaxPayload:  max_payload_q <= cfg_data[15:0];
				rvp_pkg::RegPayloadKind: kind_q <= cfg_data[6:0];
				rvp_pkg::RegSyncSource:  ssrc_q <= cfg_data;
				// seq_start lives in the back stage counter
				rvp_pkg::RegSeqStart:    ;
				rvp_pkg::RegCodec:       codec_q <= cfg_data[1:0];
				rvp_pkg::RegInterleave:  ilv_q <= cfg_data[0];
				rvp_pkg::RegJpegTq:      jtq_q <= cfg_data[15:0];
				rvp_pkg::RegJpegDims:    jdims_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end
	assign seq_load = cfg_we && cfg_index == rvp_pkg::RegSeqStart;

	logic          f_valid, q_full, q_ne, q_take;
	rvp_pkg::job_t f_job, q_job;

	rvp_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.data_byte, .frame_first, .frame_length, .frame_time, .param_frame,
		.max_payload(max_payload_q), .codec_select(codec_q),
		.job_valid(f_valid), .job(f_job), .job_full(q_full)
	);

	rvp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr(f_valid), .wdata(f_job), .full(q_full),
		.nonempty(q_ne), .rdata(q_job), .rd(q_take)
	);

	rvp_back u_back (
		.clk, .arst_n, .job_valid(q_ne), .job(q_job), .job_take(q_take),
		.payload_kind(kind_q), .sync_source(ssrc_q), .seq_start(cfg_data[15:0]),
		.seq_load, .codec_select(codec_q), .interleave_on(ilv_q),
		.jpeg_type_quality(jtq_q), .jpeg_dims(jdims_q),
		.valid(out_valid), .stall(out_stall), .out_byte, .packet_first, .packet_last
	);

	// a stalled output word holds all of its fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({out_byte, packet_first, packet_last}))
		else $error("output word changed under stall");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({out_byte, packet_first, packet_last}))
		else $error("unknown bits in output word");
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_index)) else $error("unknown register index");
endmodule
`default_nettype wire

@@ rtl/rvp_front.sv @@
`default_nettype none
module rvp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	output logic               stall,
	input  wire logic [7:0]    data_byte,
	input  wire logic          frame_first,
	input  wire logic [23:0]   frame_length,
	input  wire logic [31:0]   frame_time,
	input  wire logic          param_frame,
	input  wire logic [15:0]   max_payload,
	input  wire logic [1:0]    codec_select,
	output logic               job_valid,
	output rvp_pkg::job_t      job,
	input  wire logic          job_full
);
	logic [23:0] left_q, offset_q;
	logic [15:0] inpkt_q;
	logic [7:0]  fu_ind_q, fu_hdr_q;
	logic [31:0] stamp_q;
	logic        param_q, frag_q;

	logic [15:0] mp;
	logic        acc, fragnow, go;
	logic [23:0] left_c, off_c;
	logic [15:0] inpkt_c;
	logic        frag_c, param_c;
	logic [7:0]  hdr_c;
	logic        lastpkt;
	logic [15:0] pay;
	logic        h264, mpeg;

	assign stall = job_full;
	assign acc   = valid && !job_full;
	assign mp    = (max_payload == 16'd0) ? 16'd1 : max_payload;
	assign h264  = codec_select == rvp_pkg::CodecH264;
	assign mpeg  = !h264 && codec_select != rvp_pkg::CodecMjpeg;

	always_comb begin
		left_c  = left_q;
		off_c   = offset_q;
		inpkt_c = inpkt_q;
		frag_c  = frag_q;
		param_c = param_q;
		hdr_c   = fu_hdr_q;
		fragnow = 1'b0;
		go      = 1'b0;
		if (frame_first) begin
			inpkt_c = '0;
			off_c   = '0;
			if (frame_length != 24'd0) begin
				param_c = param_frame;
				left_c  = frame_length;
				frag_c  = 1'b0;
				go      = 1'b1;
				if (h264 && frame_length > {8'd0, mp}) begin
					frag_c  = 1'b1;
					fragnow = 1'b1;
					hdr_c   = (data_byte & 8'h1f) | rvp_pkg::FuStart;
					left_c  = frame_length - 24'd1;
				end
			end else begin
				left_c  = '0;
				param_c = 1'b0;
				frag_c  = 1'b0;
			end
		end else begin
			go = left_q != 24'd0;
		end
		lastpkt = left_c <= {8'd0, mp};
		pay     = lastpkt ? left_c[15:0] : mp;
	end

	always_comb begin
		job          = '0;
		job.data     = data_byte;
		job.start    = fragnow || inpkt_c == 16'd0;
		job.hdr_only = fragnow;
		job.last     = !fragnow && (job.start ? pay == 16'd1 : inpkt_c == 16'd1);
		job.fu       = h264 && frag_c;
		job.fu_ind   = fragnow ? ((data_byte & 8'he0) | rvp_pkg::FuTypeA) : fu_ind_q;
		job.fu_hdr   = hdr_c | (lastpkt ? rvp_pkg::FuEnd : 8'd0);
		job.pay      = pay;
		job.offset   = off_c;
		job.stamp    = (frame_first && frame_length != 24'd0) ? frame_time : stamp_q;
		if (h264)
			job.marker = lastpkt && !param_c;
		else if (!mpeg)
			job.marker = lastpkt;
		else
			job.marker = (off_c == 24'd0 && lastpkt) ? !param_c : lastpkt;
	end
	assign job_valid = acc && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0; offset_q <= '0; inpkt_q <= '0;
			fu_ind_q <= '0; fu_hdr_q <= '0; stamp_q <= '0;
			param_q <= 1'b0; frag_q <= 1'b0;
		end else if (acc) begin
			param_q <= param_c;
			frag_q  <= frag_c;
			if (frame_first && frame_length != 24'd0)
				stamp_q <= frame_time;
			if (fragnow) begin
				fu_ind_q <= job.fu_ind;
				// start bit goes away after the first fragment header
				fu_hdr_q <= hdr_c & ~rvp_pkg::FuStart;
				left_q   <= left_c;
				offset_q <= off_c;
				inpkt_q  <= pay;
			end else if (go) begin
				fu_hdr_q <= job.start ? (job.fu_hdr & ~rvp_pkg::FuStart) : hdr_c;
				left_q   <= left_c - 24'd1;
				offset_q <= off_c + 24'd1;
				inpkt_q  <= (job.start ? pay : inpkt_c) - 16'd1;
			end else begin
				left_q   <= left_c;
				offset_q <= off_c;
				inpkt_q  <= inpkt_c;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> !job_full) else $error("job pushed into full queue");
	a_hdr_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.hdr_only |-> job.start && !job.last)
		else $error("header-only job without packet start");
	a_start_pay: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job.start |-> job.pay != 16'd0) else $error("packet with no payload");
endmodule
`default_nettype wire

@@ rtl/rvp_queue.sv @@
`default_nettype none
module rvp_queue #(
	parameter int unsigned Depth = rvp_pkg::QueueDepth
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire rvp_pkg::job_t wdata,
	output logic               full,
	output logic               nonempty,
	output rvp_pkg::job_t      rdata,
	input  wire logic          rd
);
	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
	rvp_pkg::job_t mem_q [Depth];
	logic [Aw-1:0] wp_q, rp_q;
	logic [Aw:0]   cnt_q;

	assign full     = cnt_q == (Aw+1)'(Depth);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rp_q];

	function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
		return (p == Aw'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr && !full)
				wp_q <= inc(wp_q);
			if (rd && nonempty)
				rp_q <= inc(rp_q);
			cnt_q <= cnt_q + (Aw+1)'(wr && !full) - (Aw+1)'(rd && nonempty);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Aw+1)'(Depth)) else $error("queue count overrun");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd |=> full) else $error("queue lost entries while full");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q) else $error("queue pointers out of step");
endmodule
`default_nettype wire

@@ rtl/rvp_back.sv @@
`default_nettype none
module rvp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	input  wire rvp_pkg::job_t job,
	output logic               job_take,
	input  wire logic [6:0]    payload_kind,
	input  wire logic [31:0]   sync_source,
	input  wire logic [15:0]   seq_start,
	input  wire logic          seq_load,
	input  wire logic [1:0]    codec_select,
	input  wire logic          interleave_on,
	input  wire logic [15:0]   jpeg_type_quality,
	input  wire logic [15:0]   jpeg_dims,
	output logic               valid,
	input  wire logic          stall,
	output logic [7:0]         out_byte,
	output logic               packet_first,
	output logic               packet_last
);
	// header byte index: 0..3 prefix, 4..15 rtp, 16..23 payload header, 24 payload
	logic [4:0]  idx_q;
	logic        busy_q;
	logic [15:0] seq_q;
	logic        mj;
	logic [4:0]  first_idx, end_idx, nidx;
	logic [15:0] plen, len;
	logic [7:0]  b;
	logic        free, emit_pay, done;

	assign mj        = codec_select == rvp_pkg::CodecMjpeg;
	assign first_idx = interleave_on ? 5'd0 : 5'd4;
	assign end_idx   = mj ? 5'd24 : (job.fu ? 5'd18 : 5'd16);
	assign plen      = mj ? 16'd8 : (job.fu ? 16'd2 : 16'd0);
	assign len       = job.pay + 16'd12 + plen;
	assign free      = !valid || !stall;
	assign nidx      = busy_q ? idx_q : first_idx;
	assign emit_pay  = !job.start || (busy_q && idx_q == end_idx);

	always_comb begin
		unique case (nidx)
			5'd0: b = rvp_pkg::IlvMagic;
			5'd1: b = 8'd0;
			5'd2: b = len[15:8];
			5'd3: b = len[7:0];
			5'd4: b = rvp_pkg::RtpVer;
			5'd5: b = {job.marker, payload_kind};
			5'd6: b = seq_q[15:8];
			5'd7: b = seq_q[7:0];
			5'd8: b = job.stamp[31:24];
			5'd9: b = job.stamp[23:16];
			5'd10: b = job.stamp[15:8];
			5'd11: b = job.stamp[7:0];
			5'd12: b = sync_source[31:24];
			5'd13: b = sync_source[23:16];
			5'd14: b = sync_source[15:8];
			5'd15: b = sync_source[7:0];
			5'd16: b = mj ? 8'd0 : job.fu_ind;
			5'd17: b = mj ? job.offset[23:16] : job.fu_hdr;
			5'd18: b = job.offset[15:8];
			5'd19: b = job.offset[7:0];
			5'd20: b = jpeg_type_quality[15:8];
			5'd21: b = jpeg_type_quality[7:0];
			5'd22: b = jpeg_dims[15:8];
			5'd23: b = jpeg_dims[7:0];
			default: b = job.data;
		endcase
	end

	// hdr_only job ends when the header runs out, payload job emits its byte
	assign done = job_valid && free && (emit_pay ||
		(job.hdr_only && busy_q && idx_q == end_idx - 5'd1) ||
		(job.hdr_only && !busy_q && first_idx == end_idx - 5'd1));
	assign job_take = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0; busy_q <= 1'b0; idx_q <= '0; seq_q <= '0;
			out_byte <= '0; packet_first <= 1'b0; packet_last <= 1'b0;
		end else begin
			if (seq_load)
				seq_q <= seq_start;
			if (free) begin
				valid <= job_valid;
				if (job_valid) begin
					if (emit_pay) begin
						busy_q       <= 1'b0;
						out_byte     <= job.data;
						packet_first <= 1'b0;
						packet_last  <= job.last;
					end else begin
						out_byte     <= b;
						packet_first <= !busy_q;
						packet_last  <= 1'b0;
						// sequence number advances once its low byte is out
						if (nidx == 5'd7 && !seq_load)
							seq_q <= seq_q + 16'd1;
						busy_q <= !done;
						idx_q  <= nidx + 5'd1;
					end
				end
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(out_byte)) else $error("output changed under stall");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid && packet_first |-> !packet_last) else $error("first and last together");
	a_busy_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= 5'd24) else $error("header index overran");
endmodule
`default_nettype wire
